// ----- rtl/stt_pkg.sv -----
// shared constants, codes and character classes for the source text tokenizer
package stt_pkg;

	// default position counter widths
	localparam int OFFSET_BITS_DEF = 24;
	localparam int LINE_BITS_DEF   = 20;
	localparam int COLUMN_BITS_DEF = 16;

	// fixed payload widths
	localparam int KIND_W = 6;
	localparam int VAL_W  = 31;
	localparam int LEN_W  = 16;
	localparam int KBUF_W = 48;

	localparam logic [VAL_W-1:0] INT_SAT = {VAL_W{1'b1}};
	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

	// scan modes
	localparam logic [2:0] M_IDLE    = 3'd0;
	localparam logic [2:0] M_OP      = 3'd1;
	localparam logic [2:0] M_COMMENT = 3'd2;
	localparam logic [2:0] M_NUMBER  = 3'd3;
	localparam logic [2:0] M_WORD    = 3'd4;
	localparam logic [2:0] M_STRING  = 3'd5;

	// token kinds
	localparam logic [KIND_W-1:0] K_NONE    = 6'd0;
	localparam logic [KIND_W-1:0] K_EOF     = 6'd0;
	localparam logic [KIND_W-1:0] K_LPAREN  = 6'd1;
	localparam logic [KIND_W-1:0] K_RPAREN  = 6'd2;
	localparam logic [KIND_W-1:0] K_LBRACE  = 6'd3;
	localparam logic [KIND_W-1:0] K_RBRACE  = 6'd4;
	localparam logic [KIND_W-1:0] K_SEMI    = 6'd5;
	localparam logic [KIND_W-1:0] K_COLON   = 6'd6;
	localparam logic [KIND_W-1:0] K_TILDE   = 6'd7;
	localparam logic [KIND_W-1:0] K_AMP     = 6'd8;
	localparam logic [KIND_W-1:0] K_ANDAND  = 6'd9;
	localparam logic [KIND_W-1:0] K_BANG    = 6'd10;
	localparam logic [KIND_W-1:0] K_NE      = 6'd11;
	localparam logic [KIND_W-1:0] K_LT      = 6'd12;
	localparam logic [KIND_W-1:0] K_LE      = 6'd13;
	localparam logic [KIND_W-1:0] K_GT      = 6'd14;
	localparam logic [KIND_W-1:0] K_GE      = 6'd15;
	localparam logic [KIND_W-1:0] K_ASSIGN  = 6'd16;
	localparam logic [KIND_W-1:0] K_EQ      = 6'd17;
	localparam logic [KIND_W-1:0] K_BAR     = 6'd18;
	localparam logic [KIND_W-1:0] K_OROR    = 6'd19;
	localparam logic [KIND_W-1:0] K_PLUS    = 6'd20;
	localparam logic [KIND_W-1:0] K_INC     = 6'd21;
	localparam logic [KIND_W-1:0] K_PLUSEQ  = 6'd22;
	localparam logic [KIND_W-1:0] K_MINUS   = 6'd23;
	localparam logic [KIND_W-1:0] K_DEC     = 6'd24;
	localparam logic [KIND_W-1:0] K_MINUSEQ = 6'd25;
	localparam logic [KIND_W-1:0] K_SLASH   = 6'd26;
	localparam logic [KIND_W-1:0] K_STAR    = 6'd27;
	localparam logic [KIND_W-1:0] K_PERCENT = 6'd28;
	localparam logic [KIND_W-1:0] K_FN      = 6'd29;
	localparam logic [KIND_W-1:0] K_RETURN  = 6'd30;
	localparam logic [KIND_W-1:0] K_INT     = 6'd31;
	localparam logic [KIND_W-1:0] K_LET     = 6'd32;
	localparam logic [KIND_W-1:0] K_NUM     = 6'd33;
	localparam logic [KIND_W-1:0] K_IDENT   = 6'd34;
	localparam logic [KIND_W-1:0] K_STRING  = 6'd35;
	localparam logic [KIND_W-1:0] K_BADCHAR = 6'd36;
	localparam logic [KIND_W-1:0] K_UNTERM  = 6'd37;

	// keyword spellings, right aligned
	localparam logic [KBUF_W-1:0] KW_FN     = 48'h0000_0000_666E;
	localparam logic [KBUF_W-1:0] KW_RETURN = 48'h7265_7475_726E;
	localparam logic [KBUF_W-1:0] KW_INT    = 48'h0000_0069_6E74;
	localparam logic [KBUF_W-1:0] KW_LET    = 48'h0000_006C_6574;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_word_start(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
			|| (c == 8'h5F);
	endfunction

	function automatic logic is_word_char(input logic [7:0] c);
		return is_word_start(c) || is_digit(c);
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
	endfunction

	// kind of a one-character operator, K_NONE if none
	function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] c);
		logic [KIND_W-1:0] k;
		unique case (c)
			8'h28: k = K_LPAREN;
			8'h29: k = K_RPAREN;
			8'h7B: k = K_LBRACE;
			8'h7D: k = K_RBRACE;
			8'h3B: k = K_SEMI;
			8'h3A: k = K_COLON;
			8'h7E: k = K_TILDE;
			8'h26: k = K_AMP;
			8'h21: k = K_BANG;
			8'h3C: k = K_LT;
			8'h3E: k = K_GT;
			8'h3D: k = K_ASSIGN;
			8'h7C: k = K_BAR;
			8'h2B: k = K_PLUS;
			8'h2D: k = K_MINUS;
			8'h2F: k = K_SLASH;
			8'h2A: k = K_STAR;
			8'h25: k = K_PERCENT;
			default: k = K_NONE;
		endcase
		return k;
	endfunction

	// first byte of an operator that may take a second byte
	function automatic logic starts_pair(input logic [7:0] c);
		return (c == 8'h26) || (c == 8'h21) || (c == 8'h3C) || (c == 8'h3E)
			|| (c == 8'h3D) || (c == 8'h7C) || (c == 8'h2B) || (c == 8'h2D)
			|| (c == 8'h2F);
	endfunction

	// kind of the two-character operator h,c, K_NONE if none (comment opener excluded)
	function automatic logic [KIND_W-1:0] pair_kind(input logic [7:0] h, input logic [7:0] c);
		logic [KIND_W-1:0] k;
		unique case (h)
			8'h26: k = (c == 8'h26) ? K_ANDAND : K_NONE;
			8'h21: k = (c == 8'h3D) ? K_NE : K_NONE;
			8'h3C: k = (c == 8'h3D) ? K_LE : K_NONE;
			8'h3E: k = (c == 8'h3D) ? K_GE : K_NONE;
			8'h3D: k = (c == 8'h3D) ? K_EQ : K_NONE;
			8'h7C: k = (c == 8'h7C) ? K_OROR : K_NONE;
			8'h2B: k = (c == 8'h2B) ? K_INC : ((c == 8'h3D) ? K_PLUSEQ : K_NONE);
			8'h2D: k = (c == 8'h2D) ? K_DEC : ((c == 8'h3D) ? K_MINUSEQ : K_NONE);
			default: k = K_NONE;
		endcase
		return k;
	endfunction

endpackage

// ----- rtl/stt_if.sv -----
// byte input and token output channel interfaces
interface stt_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] in_byte;

	modport source(output valid, output action, output in_byte, input ready);
	modport sink(input valid, input action, input in_byte, output ready);
endinterface

interface stt_out_if #(
	parameter int LINE_BITS   = 20,
	parameter int COLUMN_BITS = 16,
	parameter int OFFSET_BITS = 24
);
	logic                   valid;
	logic                   ready;
	logic [5:0]             token_kind;
	logic [30:0]            int_value;
	logic [LINE_BITS-1:0]   token_line;
	logic [COLUMN_BITS-1:0] token_column;
	logic [OFFSET_BITS-1:0] start_offset;
	logic [15:0]            text_length;
	logic                   last_of_run;

	modport source(output valid, output token_kind, output int_value, output token_line,
		output token_column, output start_offset, output text_length, output last_of_run,
		input ready);
	modport sink(input valid, input token_kind, input int_value, input token_line,
		input token_column, input start_offset, input text_length, input last_of_run,
		output ready);
endinterface

// ----- rtl/stt_lexer.sv -----
// scanner state and per-byte token recognition, up to two tokens per transfer
module stt_lexer #(
	parameter int LINE_BITS   = stt_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = stt_pkg::COLUMN_BITS_DEF,
	parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF,
	parameter int TOK_W       = 6 + 31 + LINE_BITS + COLUMN_BITS + OFFSET_BITS + 16 + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic             action,
	input  logic [7:0]       in_byte,
	output logic [TOK_W-1:0] tok0,
	output logic [TOK_W-1:0] tok1,
	output logic [1:0]       push_n
);
	import stt_pkg::*;

	typedef struct packed {
		logic [KIND_W-1:0]      kind;
		logic [VAL_W-1:0]       val;
		logic [LINE_BITS-1:0]   line;
		logic [COLUMN_BITS-1:0] col;
		logic [OFFSET_BITS-1:0] off;
		logic [LEN_W-1:0]       len;
		logic                   last;
	} tok_t;

	localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
	localparam logic [COLUMN_BITS-1:0] COL_MAX  = {COLUMN_BITS{1'b1}};
	localparam logic [OFFSET_BITS-1:0] OFF_MAX  = {OFFSET_BITS{1'b1}};

	// scanner state
	logic [2:0]             mode_q, mode_d;
	logic [7:0]             held_q, held_d;
	logic [LINE_BITS-1:0]   line_q, line_d, sline_q, sline_d;
	logic [COLUMN_BITS-1:0] col_q, col_d, scol_q, scol_d;
	logic [OFFSET_BITS-1:0] off_q, off_d, soff_q, soff_d;
	logic [VAL_W-1:0]       num_q, num_d;
	logic [LEN_W-1:0]       wlen_q, wlen_d;
	logic [KBUF_W-1:0]      kbuf_q, kbuf_d;

	logic [OFFSET_BITS-1:0] off_inc;
	logic [LEN_W-1:0]       wlen_inc;
	logic [VAL_W+3:0]       num_next;
	logic [KIND_W-1:0]      pk, word_kind;
	logic                   pre_v, post_v;
	tok_t                   pre_t, post_t, t0, t1;

	function automatic tok_t mk(input logic [KIND_W-1:0] k, input logic [VAL_W-1:0] v,
		input logic [LINE_BITS-1:0] l, input logic [COLUMN_BITS-1:0] cl,
		input logic [OFFSET_BITS-1:0] o, input logic [LEN_W-1:0] n);
		tok_t t;
		t.kind = k;
		t.val  = v;
		t.line = l;
		t.col  = cl;
		t.off  = o;
		t.len  = n;
		t.last = 1'b0;
		return t;
	endfunction

	assign off_inc  = (off_q == OFF_MAX) ? off_q : off_q + 1'b1;
	assign wlen_inc = (wlen_q == LEN_MAX) ? wlen_q : wlen_q + 1'b1;
	assign num_next = ({4'd0, num_q} << 3) + ({4'd0, num_q} << 1)
		+ {{VAL_W{1'b0}}, in_byte[3:0]};
	assign pk       = pair_kind(held_q, in_byte);

	// keyword match on the pending word
	always_comb begin
		word_kind = K_IDENT;
		if (wlen_q == LEN_W'(2) && kbuf_q == KW_FN) word_kind = K_FN;
		else if (wlen_q == LEN_W'(6) && kbuf_q == KW_RETURN) word_kind = K_RETURN;
		else if (wlen_q == LEN_W'(3) && kbuf_q == KW_INT) word_kind = K_INT;
		else if (wlen_q == LEN_W'(3) && kbuf_q == KW_LET) word_kind = K_LET;
	end

	// next state and emitted tokens
	always_comb begin
		logic run_dispatch;
		tok_t word_t;
		mode_d = mode_q;
		held_d = held_q;
		sline_d = sline_q;
		scol_d = scol_q;
		soff_d = soff_q;
		num_d = num_q;
		wlen_d = wlen_q;
		kbuf_d = kbuf_q;
		line_d = line_q;
		col_d = col_q;
		off_d = off_q;
		pre_v = 1'b0;
		post_v = 1'b0;
		run_dispatch = 1'b0;
		word_t = mk(word_kind, '0, sline_q, scol_q, soff_q,
			(word_kind == K_IDENT) ? wlen_q : '0);
		pre_t = mk(K_NONE, '0, sline_q, scol_q, soff_q, '0);
		post_t = mk(K_EOF, '0, line_q, col_q, off_q, '0);

		if (action) begin
			// end of source: pending token, then eof, then back to reset values
			unique case (mode_q)
				M_OP: begin
					pre_v = 1'b1;
					pre_t.kind = single_kind(held_q);
				end
				M_NUMBER: begin
					pre_v = 1'b1;
					pre_t.kind = K_NUM;
					pre_t.val = num_q;
				end
				M_WORD: begin
					pre_v = 1'b1;
					pre_t = word_t;
				end
				M_STRING: begin
					pre_v = 1'b1;
					pre_t.kind = K_UNTERM;
					pre_t.len = wlen_q;
				end
				default: pre_v = 1'b0;
			endcase
			post_v = 1'b1;
			mode_d = M_IDLE;
			held_d = '0;
			sline_d = '0;
			scol_d = '0;
			soff_d = '0;
			num_d = '0;
			wlen_d = '0;
			kbuf_d = '0;
			line_d = '0;
			col_d = '0;
			off_d = '0;
		end else begin
			unique case (mode_q)
				M_OP: begin
					if (held_q == 8'h2F && in_byte == 8'h2F) begin
						mode_d = M_COMMENT;
					end else if (pk != K_NONE) begin
						pre_v = 1'b1;
						pre_t.kind = pk;
						mode_d = M_IDLE;
					end else begin
						pre_v = 1'b1;
						pre_t.kind = single_kind(held_q);
						run_dispatch = 1'b1;
					end
				end
				M_COMMENT: begin
					if (in_byte == 8'h0A) mode_d = M_IDLE;
				end
				M_NUMBER: begin
					if (is_digit(in_byte)) begin
						num_d = (num_next > {4'd0, INT_SAT}) ? INT_SAT : num_next[VAL_W-1:0];
					end else begin
						pre_v = 1'b1;
						pre_t.kind = K_NUM;
						pre_t.val = num_q;
						run_dispatch = 1'b1;
					end
				end
				M_WORD: begin
					if (is_word_char(in_byte)) begin
						if (wlen_q < LEN_W'(6)) kbuf_d = {kbuf_q[KBUF_W-9:0], in_byte};
						wlen_d = wlen_inc;
					end else begin
						pre_v = 1'b1;
						pre_t = word_t;
						run_dispatch = 1'b1;
					end
				end
				M_STRING: begin
					if (in_byte == 8'h22) begin
						pre_v = 1'b1;
						pre_t.kind = K_STRING;
						pre_t.len = wlen_q;
						mode_d = M_IDLE;
					end else begin
						wlen_d = wlen_inc;
					end
				end
				default: run_dispatch = 1'b1;
			endcase

			// start of a new token with nothing pending
			if (run_dispatch) begin
				mode_d = M_IDLE;
				post_t = mk(K_BADCHAR, '0, line_q, col_q, off_q, '0);
				if (is_blank(in_byte)) begin
					mode_d = M_IDLE;
				end else if (starts_pair(in_byte)) begin
					mode_d = M_OP;
					held_d = in_byte;
					sline_d = line_q;
					scol_d = col_q;
					soff_d = off_q;
				end else if (single_kind(in_byte) != K_NONE) begin
					post_v = 1'b1;
					post_t.kind = single_kind(in_byte);
				end else if (is_digit(in_byte)) begin
					mode_d = M_NUMBER;
					num_d = {{(VAL_W-4){1'b0}}, in_byte[3:0]};
					sline_d = line_q;
					scol_d = col_q;
					soff_d = off_q;
				end else if (is_word_start(in_byte)) begin
					mode_d = M_WORD;
					wlen_d = LEN_W'(1);
					kbuf_d = {{(KBUF_W-8){1'b0}}, in_byte};
					sline_d = line_q;
					scol_d = col_q;
					soff_d = off_q;
				end else if (in_byte == 8'h22) begin
					mode_d = M_STRING;
					wlen_d = '0;
					sline_d = line_q;
					scol_d = col_q;
					soff_d = off_inc;
				end else begin
					post_v = 1'b1;
				end
			end

			// position of the next byte
			if (in_byte == 8'h0A) begin
				line_d = (line_q == LINE_MAX) ? line_q : line_q + 1'b1;
				col_d = '0;
			end else begin
				col_d = (col_q == COL_MAX) ? col_q : col_q + 1'b1;
			end
			off_d = off_inc;
		end
	end

	// order the tokens and mark the last one
	always_comb begin
		t0 = pre_v ? pre_t : post_t;
		t1 = post_t;
		t0.last = !(pre_v && post_v);
		t1.last = 1'b1;
		push_n = accept ? ({1'b0, pre_v} + {1'b0, post_v}) : 2'd0;
	end

	assign tok0 = t0;
	assign tok1 = t1;

	// state update on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			held_q <= '0;
			line_q <= '0;
			col_q <= '0;
			off_q <= '0;
			sline_q <= '0;
			scol_q <= '0;
			soff_q <= '0;
			num_q <= '0;
			wlen_q <= '0;
			kbuf_q <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			held_q <= held_d;
			line_q <= line_d;
			col_q <= col_d;
			off_q <= off_d;
			sline_q <= sline_d;
			scol_q <= scol_d;
			soff_q <= soff_d;
			num_q <= num_d;
			wlen_q <= wlen_d;
			kbuf_q <= kbuf_d;
		end
	end

endmodule

// ----- rtl/stt_queue.sv -----
// four-entry token queue, takes up to two tokens a cycle and gives one while out_ready is high
module stt_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [1:0]   push_n,
	input  logic [W-1:0] din0,
	input  logic [W-1:0] din1,
	output logic         room,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] dout
);
	logic [W-1:0] mem_q [4];
	logic [1:0]   wp_q, rp_q;
	logic [2:0]   cnt_q;
	logic         pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != 3'd0);
	assign room      = (cnt_q <= 3'd2);
	assign dout      = mem_q[rp_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) mem_q[wp_q] <= din0;
		if (push_n == 2'd2) mem_q[wp_q + 2'd1] <= din1;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + push_n;
			if (pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {1'b0, push_n} - {2'd0, pop};
		end
	end

endmodule

// ----- rtl/source_text_tokenizer.sv -----
// Streaming tokenizer: one source byte or end item per cycle on the byte channel
// while it is ready, tokens on the token channel. Each transfer is scanned and its
// zero, one or two tokens land in a four-entry output queue; the byte channel
// takes a new item whenever the queue has two free entries, so the block runs at
// one byte per cycle while the token side drains one token per cycle. Inputs that
// give two tokens (an operator, number or word cut off by a one-token byte, or the
// end item after a pending token) cannot be sustained back to back by the queue drain.
module source_text_tokenizer #(
	parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF,
	parameter int LINE_BITS   = stt_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = stt_pkg::COLUMN_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	stt_in_if.sink    bytes,
	stt_out_if.source tokens
);
	import stt_pkg::*;

	localparam int TOK_W = KIND_W + VAL_W + LINE_BITS + COLUMN_BITS + OFFSET_BITS + LEN_W + 1;

	typedef struct packed {
		logic [KIND_W-1:0]      kind;
		logic [VAL_W-1:0]       val;
		logic [LINE_BITS-1:0]   line;
		logic [COLUMN_BITS-1:0] col;
		logic [OFFSET_BITS-1:0] off;
		logic [LEN_W-1:0]       len;
		logic                   last;
	} tok_t;

	logic [TOK_W-1:0] tok0, tok1, qout;
	logic [1:0]       push_n;
	logic             room;
	tok_t             head;

	assign bytes.ready = room;

	// scanner
	stt_lexer #(
		.LINE_BITS(LINE_BITS),
		.COLUMN_BITS(COLUMN_BITS),
		.OFFSET_BITS(OFFSET_BITS),
		.TOK_W(TOK_W)
	) u_lexer (
		.clk(clk),
		.arst_n(arst_n),
		.accept(bytes.valid && room),
		.action(bytes.action),
		.in_byte(bytes.in_byte),
		.tok0(tok0),
		.tok1(tok1),
		.push_n(push_n)
	);

	// output queue
	stt_queue #(.W(TOK_W)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_n(push_n),
		.din0(tok0),
		.din1(tok1),
		.room(room),
		.out_valid(tokens.valid),
		.out_ready(tokens.ready),
		.dout(qout)
	);

	// token fields
	assign head                = qout;
	assign tokens.token_kind   = head.kind;
	assign tokens.int_value    = head.val;
	assign tokens.token_line   = head.line;
	assign tokens.token_column = head.col;
	assign tokens.start_offset = head.off;
	assign tokens.text_length  = head.len;
	assign tokens.last_of_run  = head.last;

endmodule
